>>> hw/rtl/ssa_pkg.sv
// Shared types and constants of the sequence slot allocator.
// Holds request/response structs, opcode and status codes, queue item type.
// No dependencies.
package ssa_pkg;

    localparam int SLOTS_DEF = 16;
    localparam logic [15:0] MAX_LEN_RST = 16'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_NO_SLOT   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        op_t         opcode;
        logic [31:0] seq_tag;
        logic [15:0] token_count;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  slot_index;
        logic [19:0] slot_offset;
        logic        is_allocated;
        logic [15:0] recorded_tokens;
        logic [4:0]  free_slots;
    } rsp_t;

    // Front-end classification carried along with each request.
    typedef struct packed {
        logic too_long;
    } cls_t;

    typedef struct packed {
        req_t req;
        cls_t cls;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hw/rtl/sequence_slot_allocator.sv
// Top level of the sequence slot allocator.
// Instantiates ssa_front, ssa_queue and ssa_back; uses ssa_pkg types.
//
// Usage:
//   Request channel: drive req (opcode, seq_tag, token_count) with start high;
//   the transaction is taken at a rising edge where start is high and busy
//   is low. Opcodes: allocate, free, lookup, clear all slots.
//   Result channel: done is high for one cycle per result, with rsp valid in that cycle.
//   Exactly one result per request, in request order. The receiver cannot
//   stall; every result is taken in the cycle it is shown.
//   Config channel: cfg_data with cfg_valid/cfg_ready writes max_len (the
//   per-sequence token limit and the slot offset stride). cfg_ready is
//   always high; write it only while no request is in flight.
// Flow and throughput:
//   A request taken at an edge is written into the queue entry; the back end
//   then pops it and registers the result and done. One request per
//   cycle is sustained: the back end retires a queued transaction every cycle,
//   as the tag match, lowest-free encoder and table next-state are combinational.
//   The queue therefore never holds more than one transaction; busy stays low.
// Reset:
//   rst_n low frees all slots, restores max_len to 4096 and empties the
//   queue. No clearing pass is needed; the block is ready right after.
module sequence_slot_allocator #(
    parameter int SLOTS = ssa_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ssa_pkg::req_t req,
    output logic          done,
    output ssa_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);
    import ssa_pkg::*;

    q_stat_t     q_stat;
    q_item_t     push_item;
    q_item_t     pop_item;
    logic        push;
    logic        pop;
    logic [15:0] max_len;

    // Accept and classify requests; hold the max_len register.
    ssa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .cfg_ready (cfg_ready),
        .busy      (busy),
        .push      (push),
        .push_item (push_item),
        .max_len   (max_len)
    );

    // Decouple front and back end so each can advance on its own.
    ssa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    // Execute transactions against the slot table and register the result.
    ssa_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .item    (pop_item),
        .max_len (max_len),
        .pop     (pop),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

>>> hw/rtl/ssa_queue.sv
// Two-entry queue between the allocator front end and back end.
// Depends on ssa_pkg for the queue item and status types.
module ssa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ssa_pkg::q_item_t push_item,
    input  logic             pop,
    output ssa_pkg::q_item_t pop_item,
    output ssa_pkg::q_stat_t stat
);
    import ssa_pkg::*;

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/ssa_front.sv
// Front end: takes requests, holds the max_len register, classifies length.
// Depends on ssa_pkg for request and queue item types.
module ssa_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ssa_pkg::req_t    req,
    input  logic             cfg_valid,
    input  logic [15:0]      cfg_data,
    input  ssa_pkg::q_stat_t q_stat,
    output logic             cfg_ready,
    output logic             busy,
    output logic             push,
    output ssa_pkg::q_item_t push_item,
    output logic [15:0]      max_len
);
    import ssa_pkg::*;

    logic [15:0] max_len_reg;

    assign cfg_ready = 1'b1;
    assign busy      = q_stat.full;
    assign push      = start && !q_stat.full;
    assign max_len   = max_len_reg;

    // Flag over-length requests up front; the user must change max_len only while idle (not enforced here).
    always_comb
    begin
        push_item.req          = req;
        push_item.cls.too_long = (req.token_count > max_len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

endmodule

>>> hw/rtl/ssa_back.sv
// Back end: slot table with tag match, lowest-free search and result register.
// Depends on ssa_pkg for queue item, response and code types.
module ssa_back #(
    parameter int SLOTS = ssa_pkg::SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ssa_pkg::q_stat_t q_stat,
    input  ssa_pkg::q_item_t item,
    input  logic [15:0]      max_len,
    output logic             pop,
    output logic             done,
    output ssa_pkg::rsp_t    rsp
);
    import ssa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int PRD_W = IDX_W + 16;

    logic [SLOTS-1:0] slot_valid_reg;
    logic [SLOTS-1:0] slot_valid_next;
    logic [31:0]      slot_owner_reg  [SLOTS];
    logic [15:0]      slot_tokens_reg [SLOTS];
    logic [CNT_W-1:0] free_cnt_reg;
    logic [CNT_W-1:0] free_cnt_next;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [SLOTS-1:0] hit_vec;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] sel_idx;
    logic [15:0]      cur_tok;
    logic             has_slot;
    logic             wr_tok_en;
    logic             wr_owner_en;
    logic [IDX_W-1:0] wr_idx;
    logic [15:0]      wr_tok;
    logic [PRD_W-1:0] prod;

    assign pop  = !q_stat.empty;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Parallel tag match and lowest-index encoders.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_vec[i] = slot_valid_reg[i] && (slot_owner_reg[i] == item.req.seq_tag);
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign cur_tok = slot_tokens_reg[hit_idx];

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        free_cnt_next   = free_cnt_reg;
        wr_tok_en       = 1'b0;
        wr_owner_en     = 1'b0;
        wr_idx          = hit_idx;
        wr_tok          = item.req.token_count;
        sel_idx         = hit_idx;
        has_slot        = 1'b0;
        rsp_next        = '0;
        rsp_next.status = ST_OK;
        if (pop)
        begin
            unique case (item.req.opcode)
                OP_ALLOC:
                begin
                    if (|hit_vec)
                    begin
                        has_slot              = 1'b1;
                        rsp_next.is_allocated = 1'b1;
                        rsp_next.recorded_tokens = cur_tok;
                        if (item.cls.too_long)
                        begin
                            rsp_next.status = ST_TOO_LONG;
                        end
                        else if (item.req.token_count > cur_tok)
                        begin
                            wr_tok_en = 1'b1;
                            rsp_next.recorded_tokens = item.req.token_count;
                        end
                    end
                    else if (&slot_valid_reg)
                    begin
                        rsp_next.status = ST_NO_SLOT;
                    end
                    else if (item.cls.too_long)
                    begin
                        rsp_next.status = ST_TOO_LONG;
                    end
                    else
                    begin
                        wr_idx                   = free_idx;
                        wr_tok_en                = 1'b1;
                        wr_owner_en              = 1'b1;
                        sel_idx                  = free_idx;
                        has_slot                 = 1'b1;
                        slot_valid_next[free_idx] = 1'b1;
                        free_cnt_next            = free_cnt_reg - CNT_W'(1);
                        rsp_next.is_allocated    = 1'b1;
                        rsp_next.recorded_tokens = item.req.token_count;
                    end
                end
                OP_FREE:
                begin
                    if (|hit_vec)
                    begin
                        has_slot                 = 1'b1;
                        slot_valid_next[hit_idx] = 1'b0;
                        free_cnt_next            = free_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                end
                OP_LOOKUP:
                begin
                    if (|hit_vec)
                    begin
                        has_slot                 = 1'b1;
                        rsp_next.is_allocated    = 1'b1;
                        rsp_next.recorded_tokens = cur_tok;
                    end
                    else
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                end
                OP_CLEAR:
                begin
                    slot_valid_next = '0;
                    free_cnt_next   = CNT_W'(SLOTS);
                end
            endcase
        end
        prod = PRD_W'(sel_idx) * PRD_W'(max_len);
        if (has_slot)
        begin
            rsp_next.slot_index  = 4'(sel_idx);
            rsp_next.slot_offset = 20'(prod);
        end
        rsp_next.free_slots = 5'(free_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            free_cnt_reg   <= CNT_W'(SLOTS);
            done_reg       <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            free_cnt_reg   <= free_cnt_next;
            done_reg       <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (wr_tok_en)
        begin
            slot_tokens_reg[wr_idx] <= wr_tok;
        end
        if (wr_owner_en)
        begin
            slot_owner_reg[wr_idx] <= item.req.seq_tag;
        end
    end

`ifndef SYNTHESIS
    a_free_cnt_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg == CNT_W'($countones(~slot_valid_reg)))
        else $error("free slot count out of step with valid bits");

    a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> $onehot0(hit_vec))
        else $error("sequence tag held by more than one slot");

    a_result_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> done_reg)
        else $error("transaction popped without a result");

    a_result_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rsp_reg.free_slots == 5'(free_cnt_reg))
        else $error("reported free slot count differs from table");
`endif

endmodule
